/* hdl/lpc_pkg.sv */
// lpc_pkg: shared types and constants of the lidar point colorizer
// request and response beat structs, csr register indexes, pixel coordinate width
// no dependencies
`timescale 1ns / 1ps

package lpc_pkg;

   typedef struct packed {
      logic               action;
      logic [9:0]         pixel_col;
      logic [8:0]         pixel_row;
      logic [7:0]         red_in;
      logic [7:0]         green_in;
      logic [7:0]         blue_in;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic [7:0]         red_out;
      logic [7:0]         green_out;
      logic [7:0]         blue_out;
   } rsp_type;

   // result of one projection unit
   localparam int COORD_W = 20;

   typedef struct packed {
      logic                       done;
      logic signed [COORD_W-1:0]  coord;
   } proj_out_type;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_POINT = 1'b1;

   localparam logic [2:0] CSR_FOCAL   = 3'd0;
   localparam logic [2:0] CSR_CCOL    = 3'd1;
   localparam logic [2:0] CSR_CROW    = 3'd2;
   localparam logic [2:0] CSR_SHIFT_X = 3'd3;
   localparam logic [2:0] CSR_SHIFT_Y = 3'd4;
   localparam logic [2:0] CSR_SHIFT_Z = 3'd5;

endpackage

/* hdl/lpc_proj.sv */
// lpc_proj: pinhole projection of one axis, round((f*a/z + c) / 65536) with saturated quotient
// one multiply, then a bit-serial restoring divider over 32 quotient bits
// depends on lpc_pkg
`timescale 1ns / 1ps

module lpc_proj (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [31:0]   coord_a,
   input  logic [31:0]          depth_z,
   input  logic [30:0]          focal,
   input  logic [30:0]          center,
   output lpc_pkg::proj_out_type result
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_PRE  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        neg_ff, neg_in;
   logic [62:0] mag_ff, mag_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        ovf_ff, ovf_in;
   logic        done_ff, done_in;
   logic signed [lpc_pkg::COORD_W-1:0] coord_ff, coord_in;

   logic signed [63:0] prod;
   logic [31:0]        shifted;
   logic               ge;
   logic               nz;
   logic               sat_pos, sat_neg;
   logic signed [35:0] qv, term, wsum;
   logic [35:0]        wmag;
   logic [18:0]        rnd;

   always_comb begin
      prod    = $signed({1'b0, focal}) * coord_a;
      shifted = {rem_ff[30:0], quo_ff[31]};
      ge      = shifted >= depth_z;
      nz      = rem_ff != 32'd0;
      sat_pos = !neg_ff && (ovf_ff || quo_ff[31]);
      sat_neg = neg_ff && (ovf_ff || (quo_ff > 32'h8000_0000) ||
                           (quo_ff == 32'h8000_0000 && nz));
      if (!neg_ff && quo_ff == 32'h7FFF_FFFF && nz) begin
         sat_pos = 1'b1;
      end
      // twice the truncated quotient, plus one when a remainder is left over
      qv = $signed({3'b000, quo_ff, nz});
      if (neg_ff) begin
         qv = -qv;
      end
      if (sat_pos) begin
         term = 36'sh0_FFFF_FFFE;
      end else if (sat_neg) begin
         term = -36'sh1_0000_0000;
      end else begin
         term = qv;
      end
      wsum = term + $signed({4'b0000, center, 1'b0});
      wmag = wsum[35] ? 36'(-wsum) : wsum;
      rnd  = wmag[35:17] + 19'(wmag[16]);
   end

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      coord_in = coord_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            neg_in   = prod[63];
            mag_in   = prod[63] ? 63'(-prod) : prod[62:0];
            state_in = ST_PRE;
         end
         ST_PRE: begin
            rem_in   = {1'b0, mag_ff[62:32]};
            quo_in   = mag_ff[31:0];
            ovf_in   = {1'b0, mag_ff[62:32]} >= depth_z;
            cnt_in   = 5'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? shifted - depth_z : shifted;
            quo_in = {quo_ff[30:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            coord_in = wsum[35] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      ovf_ff   <= ovf_in;
      coord_ff <= coord_in;
   end

   assign result.done  = done_ff;
   assign result.coord = coord_ff;

endmodule

/* hdl/lidar_point_colorizer.sv */
// lidar_point_colorizer: colors lidar points from an rgb image store
// holds csr registers, image memory and the point sequencer
// depends on lpc_pkg and lpc_proj
`timescale 1ns / 1ps

// channel   ports                         beat taken when
// req       start, busy, req_data         start high and busy low
// rsp       rsp_valid, rsp_data           rsp_valid high (one cycle, no stall)
// csr       csr_valid, csr_ready, index   csr_valid and csr_ready high
//
// a pixel beat writes the image memory in the cycle it is taken, busy stays low
// a kept point passes camera transform, projection (multiply, setup, 32 divider steps,
// rounding, done), read and out, where its rsp beat is given; busy stays high until idle
// points behind the camera leave after the transform, off-image points after projection
// reset restores csr defaults; the image memory is undefined until written
// results cannot be held off, each rsp_valid pulse is exactly one beat

module lidar_point_colorizer #(
   parameter int IMAGE_WIDTH  = 640,
   parameter int IMAGE_HEIGHT = 480
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lpc_pkg::req_type req_data,
   output logic             rsp_valid,
   output lpc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CAM  = 3'd1;
   localparam logic [2:0] ST_PROJ = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // csr registers
   logic [30:0] focal_ff, ccol_ff, crow_ff;
   logic [31:0] shx_ff, shy_ff, shz_ff;

   logic [2:0]  state_ff, state_in;
   logic [31:0] camx_ff, camy_ff, camz_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [23:0] rd_ff;
   logic [23:0] mem [DEPTH];

   logic accept;
   logic pix_wr;
   logic [ADDR_W-1:0] wr_addr;
   logic proj_go;
   logic u_ok, v_ok;
   lpc_pkg::proj_out_type u_res, v_res;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= 31'd22099292;
         ccol_ff  <= 31'd21004288;
         crow_ff  <= 31'd15761408;
         shx_ff   <= 32'd0;
         shy_ff   <= 32'hFFFF_DF3B;
         shz_ff   <= 32'hFFFF_CE14;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lpc_pkg::CSR_FOCAL:   focal_ff <= csr_data[30:0];
            lpc_pkg::CSR_CCOL:    ccol_ff  <= csr_data[30:0];
            lpc_pkg::CSR_CROW:    crow_ff  <= csr_data[30:0];
            lpc_pkg::CSR_SHIFT_X: shx_ff   <= csr_data;
            lpc_pkg::CSR_SHIFT_Y: shy_ff   <= csr_data;
            lpc_pkg::CSR_SHIFT_Z: shz_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // pixel beats: write at once when inside the image
   assign pix_wr = accept && req_data.action == lpc_pkg::ACT_PIXEL &&
                   (32'(req_data.pixel_col) < 32'(IMAGE_WIDTH)) &&
                   (32'(req_data.pixel_row) < 32'(IMAGE_HEIGHT));
   assign wr_addr = ADDR_W'(ADDR_W'(req_data.pixel_row) * ADDR_W'(IMAGE_WIDTH)) +
                    ADDR_W'(req_data.pixel_col);

   always_ff @(posedge clock) begin
      if (pix_wr) begin
         mem[wr_addr] <= {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
      if (state_ff == ST_READ) begin
         rd_ff <= mem[addr_ff];
      end
   end

   // axis swap plus translation, wrapping
   always_ff @(posedge clock) begin
      if (accept) begin
         camx_ff <= shx_ff - req_data.point_y;
         camy_ff <= shy_ff - req_data.point_z;
         camz_ff <= req_data.point_x + shz_ff;
      end
   end

   // depth must be strictly positive
   assign proj_go = state_ff == ST_CAM && !camz_ff[31] && camz_ff != 32'd0;

   lpc_proj u_proj_u (
      .clock   (clock),
      .reset   (reset),
      .start   (proj_go),
      .coord_a (camx_ff),
      .depth_z (camz_ff),
      .focal   (focal_ff),
      .center  (ccol_ff),
      .result  (u_res)
   );

   lpc_proj u_proj_v (
      .clock   (clock),
      .reset   (reset),
      .start   (proj_go),
      .coord_a (camy_ff),
      .depth_z (camz_ff),
      .focal   (focal_ff),
      .center  (crow_ff),
      .result  (v_res)
   );

   assign u_ok = !u_res.coord[lpc_pkg::COORD_W-1] &&
                 (32'(u_res.coord[lpc_pkg::COORD_W-2:0]) < 32'(IMAGE_WIDTH));
   assign v_ok = !v_res.coord[lpc_pkg::COORD_W-1] &&
                 (32'(v_res.coord[lpc_pkg::COORD_W-2:0]) < 32'(IMAGE_HEIGHT));

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.action == lpc_pkg::ACT_POINT) begin
               state_in = ST_CAM;
            end
         end
         ST_CAM: begin
            state_in = proj_go ? ST_PROJ : ST_IDLE;
         end
         ST_PROJ: begin
            if (u_res.done) begin
               addr_in = ADDR_W'(ADDR_W'(v_res.coord) * ADDR_W'(IMAGE_WIDTH)) +
                         ADDR_W'(u_res.coord);
               state_in = (u_ok && v_ok) ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      addr_ff <= addr_in;
   end

   assign rsp_valid          = state_ff == ST_OUT;
   assign rsp_data.cam_x     = camx_ff;
   assign rsp_data.cam_y     = camy_ff;
   assign rsp_data.cam_z     = camz_ff;
   assign rsp_data.red_out   = rd_ff[23:16];
   assign rsp_data.green_out = rd_ff[15:8];
   assign rsp_data.blue_out  = rd_ff[7:0];

   // both axes run in lockstep
   a_proj_lockstep: assert property (@(posedge clock) disable iff (reset)
      u_res.done == v_res.done)
      else $error("projection units out of step");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held longer than one beat");

   a_point_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.action == lpc_pkg::ACT_POINT) |=> busy)
      else $error("point beat taken without going busy");

   a_done_in_proj: assert property (@(posedge clock) disable iff (reset)
      u_res.done |-> state_ff == ST_PROJ)
      else $error("projection finished outside its wait state");

endmodule

/* bench/lpc_checker.sv */
// lpc_checker: watches the req, rsp and csr channels of the lidar point colorizer,
// predicts each colored point and compares it with the rsp beats
// depends on lpc_pkg
`timescale 1ns / 1ps

module lpc_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  lpc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  lpc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data,
   output int               fail_count,
   output int               pending,
   output int               point_count,
   output int               color_count
);

   localparam int IMG_W = 640;
   localparam int IMG_H = 480;

   logic [30:0] focal, ccol, crow;
   logic [31:0] sx, sy, sz;
   logic [23:0] image_rgb [int];
   lpc_pkg::rsp_type colored_points [$];

   // n / d rounded half away from zero, d > 0
   function automatic longint round_half_away(logic signed [127:0] n,
                                              logic signed [127:0] d);
      logic                 neg;
      logic signed [127:0]  m, q, r;
      neg = n < 0;
      m   = neg ? -n : n;
      q   = m / d;
      r   = m % d;
      if (r >= d - r) q = q + 1;
      return neg ? longint'(-q) : longint'(q);
   endfunction

   // pixel coordinate of camera coordinate a at depth z > 0
   function automatic longint pinhole(logic signed [31:0] a, logic signed [31:0] z,
                                      logic [30:0] f, logic [30:0] c);
      logic signed [127:0] aa, zz, ff, cc, num, hi, lo;
      aa  = a;
      zz  = z;
      ff  = {97'd0, f};
      cc  = {97'd0, c};
      hi  = 128'sd2147483647;
      lo  = -128'sd2147483648;
      num = ff * aa;
      if (num > hi * zz) return round_half_away(hi + cc, 128'sd65536);
      if (num < lo * zz) return round_half_away(lo + cc, 128'sd65536);
      return round_half_away(num + cc * zz, zz * 128'sd65536);
   endfunction

   task automatic predict_point(lpc_pkg::req_type b);
      logic signed [31:0] cx, cy, cz;
      longint             u, v;
      lpc_pkg::rsp_type   e;
      cx = -b.point_y + sx;
      cy = -b.point_z + sy;
      cz = b.point_x + sz;
      if (cz <= 0) return;
      u = pinhole(cx, cz, focal, ccol);
      v = pinhole(cy, cz, focal, crow);
      if (u < 0 || u >= IMG_W || v < 0 || v >= IMG_H) return;
      e.cam_x = cx;
      e.cam_y = cy;
      e.cam_z = cz;
      if (!image_rgb.exists(int'(v) * IMG_W + int'(u))) begin
         $display("%0t lpc_checker: point hits unwritten pixel %0d,%0d", $time, u, v);
         fail_count++;
         {e.red_out, e.green_out, e.blue_out} = 24'd0;
      end else
         {e.red_out, e.green_out, e.blue_out} = image_rgb[int'(v) * IMG_W + int'(u)];
      colored_points = {colored_points, e};
   endtask

   always @(posedge clock) begin
      lpc_pkg::rsp_type e;
      if (reset) begin
         focal = 31'd22099292;
         ccol  = 31'd21004288;
         crow  = 31'd15761408;
         sx    = 32'd0;
         sy    = -32'sd8389;
         sz    = -32'sd12780;
         colored_points.delete();
         fail_count  = 0;
         point_count = 0;
         color_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lpc_pkg::CSR_FOCAL:   focal = csr_data[30:0];
               lpc_pkg::CSR_CCOL:    ccol  = csr_data[30:0];
               lpc_pkg::CSR_CROW:    crow  = csr_data[30:0];
               lpc_pkg::CSR_SHIFT_X: sx    = csr_data;
               lpc_pkg::CSR_SHIFT_Y: sy    = csr_data;
               lpc_pkg::CSR_SHIFT_Z: sz    = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_data.action == lpc_pkg::ACT_PIXEL) begin
               if (req_data.pixel_col < IMG_W && req_data.pixel_row < IMG_H)
                  image_rgb[int'(req_data.pixel_row) * IMG_W + int'(req_data.pixel_col)] =
                     {req_data.red_in, req_data.green_in, req_data.blue_in};
            end else begin
               point_count++;
               predict_point(req_data);
            end
         end
         if (rsp_valid) begin
            color_count++;
            if (colored_points.size() == 0) begin
               $display("%0t lpc_checker: unexpected rsp beat %h", $time, rsp_data);
               fail_count++;
            end else begin
               e = colored_points.pop_front();
               if (rsp_data.cam_x !== e.cam_x) begin
                  $display("%0t cam_x exp %h got %h", $time, e.cam_x, rsp_data.cam_x);
                  fail_count++;
               end
               if (rsp_data.cam_y !== e.cam_y) begin
                  $display("%0t cam_y exp %h got %h", $time, e.cam_y, rsp_data.cam_y);
                  fail_count++;
               end
               if (rsp_data.cam_z !== e.cam_z) begin
                  $display("%0t cam_z exp %h got %h", $time, e.cam_z, rsp_data.cam_z);
                  fail_count++;
               end
               if (rsp_data.red_out !== e.red_out) begin
                  $display("%0t red_out exp %h got %h", $time, e.red_out, rsp_data.red_out);
                  fail_count++;
               end
               if (rsp_data.green_out !== e.green_out) begin
                  $display("%0t green_out exp %h got %h", $time, e.green_out,
                           rsp_data.green_out);
                  fail_count++;
               end
               if (rsp_data.blue_out !== e.blue_out) begin
                  $display("%0t blue_out exp %h got %h", $time, e.blue_out,
                           rsp_data.blue_out);
                  fail_count++;
               end
            end
         end
      end
      pending = colored_points.size();
   end

endmodule

/* bench/testbench.sv */
// testbench: stimulus and verdict for the lidar point colorizer
// writes pixels ahead of the points that land on them, then runs directed and random
// beats over several csr settings; depends on lpc_pkg, lpc_checker and lidar_point_colorizer
`timescale 1ns / 1ps

module testbench;

   localparam int IMG_W     = 640;
   localparam int IMG_H     = 480;
   localparam int WD_LIMIT  = 4000;   // idle cycles before the watchdog trips
   localparam int SETTLE    = 60;     // covers the time a point spends in flight
   localparam int PER_PHASE = 100;
   // csr indexes past the register list, must be ignored
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic             clock, reset;
   logic             start, busy;
   lpc_pkg::req_type req_data;
   logic             rsp_valid;
   lpc_pkg::rsp_type rsp_data;
   logic             csr_valid, csr_ready;
   logic [2:0]       csr_index;
   logic [31:0]      csr_data;
   int               fail_count, pending, point_count, color_count;
   int               idle_pct;
   int               quiet_cycles;

   // local copy of the csr values, used only to aim points at the image
   logic [31:0] csr_shadow [6];
   // pixels written so far, a point never lands on any other
   bit          written [int];

   lidar_point_colorizer u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   lpc_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending),
      .point_count(point_count), .color_count(color_count)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // watchdog: any beat on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WD_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // n / d rounded half away from zero, d > 0
   function automatic longint round_away(logic signed [127:0] n, logic signed [127:0] d);
      logic                 neg;
      logic signed [127:0]  m, q, r;
      neg = n < 0;
      m   = neg ? -n : n;
      q   = m / d;
      r   = m % d;
      if (r >= d - r) q = q + 1;
      return neg ? longint'(-q) : longint'(q);
   endfunction

   // pixel that camera coordinate a at depth z > 0 lands on
   function automatic longint land_pixel(logic signed [31:0] a, logic signed [31:0] z,
                                         logic [30:0] f, logic [30:0] c);
      logic signed [127:0] aa, zz, ff, cc, num, hi, lo;
      aa  = a;
      zz  = z;
      ff  = {97'd0, f};
      cc  = {97'd0, c};
      hi  = 128'sd2147483647;
      lo  = -128'sd2147483648;
      num = ff * aa;
      if (num > hi * zz) return round_away(hi + cc, 128'sd65536);
      if (num < lo * zz) return round_away(lo + cc, 128'sd65536);
      return round_away(num + cc * zz, zz * 128'sd65536);
   endfunction

   // one req beat, start held until the block takes it
   task automatic send_beat(lpc_pkg::req_type b);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
      end
      req_data = b;
      start    = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_pixel(int col, int row, logic [23:0] rgb);
      lpc_pkg::req_type b;
      b = '0;
      b.action    = lpc_pkg::ACT_PIXEL;
      b.pixel_col = col[9:0];
      b.pixel_row = row[8:0];
      {b.red_in, b.green_in, b.blue_in} = rgb;
      b.point_x = $urandom;   // don't-care fields carry noise
      b.point_y = $urandom;
      b.point_z = $urandom;
      send_beat(b);
      if (col >= 0 && col < IMG_W && row >= 0 && row < IMG_H)
         written[row * IMG_W + col] = 1'b1;
   endtask

   // lidar point from a camera frame point, undoing the axis swap and shift
   // the pixel it lands on gets written first when it is still blank
   task automatic send_cam_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      lpc_pkg::req_type b;
      longint           u, v;
      if ($signed(cz) > 0) begin
         u = land_pixel(cx, cz, csr_shadow[lpc_pkg::CSR_FOCAL][30:0],
                        csr_shadow[lpc_pkg::CSR_CCOL][30:0]);
         v = land_pixel(cy, cz, csr_shadow[lpc_pkg::CSR_FOCAL][30:0],
                        csr_shadow[lpc_pkg::CSR_CROW][30:0]);
         if (u >= 0 && u < IMG_W && v >= 0 && v < IMG_H &&
             !written.exists(int'(v) * IMG_W + int'(u)))
            write_pixel(int'(u), int'(v), 24'($urandom));
      end
      b = '0;
      b.action    = lpc_pkg::ACT_POINT;
      b.pixel_col = 10'($urandom);
      b.pixel_row = 9'($urandom);
      b.red_in    = 8'($urandom);
      b.green_in  = 8'($urandom);
      b.blue_in   = 8'($urandom);
      b.point_y   = csr_shadow[lpc_pkg::CSR_SHIFT_X] - cx;
      b.point_z   = csr_shadow[lpc_pkg::CSR_SHIFT_Y] - cy;
      b.point_x   = cz - csr_shadow[lpc_pkg::CSR_SHIFT_Z];
      send_beat(b);
   endtask

   // camera coordinate at depth z that lands near pixel p
   function automatic logic [31:0] aim_coord(int p, longint z, logic [31:0] c);
      longint f;
      f = longint'(csr_shadow[lpc_pkg::CSR_FOCAL][30:0]);
      if (f == 0) return $urandom;
      return 32'((((longint'(p) <<< 16) - longint'(c[30:0])) * z) / f
                 + $signed($urandom_range(0, 64)) - 32);
   endfunction

   task automatic send_aimed(int u, int v, longint z);
      send_cam_point(aim_coord(u, z, csr_shadow[lpc_pkg::CSR_CCOL]),
                     aim_coord(v, z, csr_shadow[lpc_pkg::CSR_CROW]), 32'(z));
   endtask

   // block idle: nothing owed, then room for a dropped point still in flight
   task automatic wait_drain();
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx <= lpc_pkg::CSR_SHIFT_Z) begin
         csr_shadow[idx] = val;
         if (idx <= lpc_pkg::CSR_CROW) csr_shadow[idx][31] = 1'b0;
      end
   endtask

   task automatic load_csr(logic [31:0] f, logic [31:0] cc, logic [31:0] cr,
                           logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
      wait_drain();
      write_csr(lpc_pkg::CSR_FOCAL, f);
      write_csr(lpc_pkg::CSR_CCOL, cc);
      write_csr(lpc_pkg::CSR_CROW, cr);
      write_csr(lpc_pkg::CSR_SHIFT_X, tx);
      write_csr(lpc_pkg::CSR_SHIFT_Y, ty);
      write_csr(lpc_pkg::CSR_SHIFT_Z, tz);
   endtask

   // random phase: mostly aimed points, some noise, behind-camera and pixel beats
   task automatic random_phase(int n);
      int     sel;
      longint z;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 15) begin
            write_pixel($urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1),
                        24'($urandom));
         end else if (sel < 20) begin
            write_pixel($urandom_range(0, 1023), $urandom_range(0, 511), 24'($urandom));
         end else if (sel < 30) begin
            send_cam_point($urandom, $urandom, $urandom);
         end else if (sel < 38) begin
            send_cam_point($urandom, $urandom, -$signed($urandom_range(0, 1 << 20)));
         end else begin
            // short depths stretch the quotient, long ones keep it small
            z = (sel < 45) ? longint'($urandom_range(1, 65536))
                           : longint'($urandom_range(6554, 40 * 65536));
            send_aimed($urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1), z);
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = lpc_pkg::CSR_FOCAL;
      csr_data  = '0;
      idle_pct  = 0;
      csr_shadow[lpc_pkg::CSR_FOCAL]   = 32'd22099292;
      csr_shadow[lpc_pkg::CSR_CCOL]    = 32'd21004288;
      csr_shadow[lpc_pkg::CSR_CROW]    = 32'd15761408;
      csr_shadow[lpc_pkg::CSR_SHIFT_X] = 32'd0;
      csr_shadow[lpc_pkg::CSR_SHIFT_Y] = -32'sd8389;
      csr_shadow[lpc_pkg::CSR_SHIFT_Z] = -32'sd12780;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: corners, out-of-image writes, extreme colors
      write_pixel(0, 0, 24'h000000);
      write_pixel(IMG_W - 1, IMG_H - 1, 24'hffffff);
      write_pixel(1023, 511, 24'h123456);
      write_pixel(IMG_W, 0, 24'habcdef);
      write_pixel(0, IMG_H, 24'h654321);
      // point on the optical axis, principal point rounds half away from zero
      send_cam_point(32'd0, 32'd0, 32'h0001_0000);
      // camera depth exactly zero, and the smallest positive depth
      send_cam_point(32'd0, 32'd0, 32'd0);
      send_cam_point(32'd0, 32'd0, 32'd1);
      // quotient saturation both ways
      send_cam_point(32'h7fff_ffff, 32'h8000_0000, 32'd1);
      send_cam_point(32'h8000_0000, 32'h7fff_ffff, 32'd1);
      // image corners and just outside
      send_aimed(0, 0, 64'h0002_0000);
      send_aimed(IMG_W - 1, IMG_H - 1, 64'h0002_0000);
      send_aimed(IMG_W + 5, 10, 64'h0002_0000);
      send_aimed(10, -5, 64'h0002_0000);
      // extreme camera frame coordinates
      send_cam_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_cam_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

      // sender pauses until every colored point has come back
      wait_drain();
      write_csr(CSR_SPARE_LO, $urandom);
      write_csr(CSR_SPARE_HI, $urandom);
      send_aimed(100, 100, 64'h0003_0000);

      // csr settings, each run with an idling mix of 0, 38 or 64 percent, the last one with two
      load_csr(32'd22099292, 32'd21004288, 32'd15761408, 32'd0, -32'sd8389, -32'sd12780);
      idle_pct = 0;
      random_phase(PER_PHASE);
      load_csr(32'h7fff_ffff, 32'd21004288, 32'd15761408, 32'h0001_0000,
               32'hffff_0000, 32'h0000_8000);
      idle_pct = 64;
      random_phase(PER_PHASE);
      load_csr(32'd0, 32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      idle_pct = 38;
      random_phase(PER_PHASE);
      load_csr(32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'h8000_0000);
      idle_pct = 0;
      random_phase(PER_PHASE);
      load_csr(32'd6553600, 32'd3276800, 32'd6553600, $urandom, $urandom,
               $urandom_range(0, 1 << 18));
      idle_pct = 64;
      random_phase(PER_PHASE);
      load_csr(32'hffff_ffff, 32'hffff_ffff, 32'd15761408, 32'd0, 32'd0, 32'd0);
      idle_pct = 38;
      random_phase(PER_PHASE);
      load_csr(32'd22099292, 32'd21004288, 32'd15761408, 32'd0, -32'sd8389, -32'sd12780);
      idle_pct = 0;
      random_phase(PER_PHASE);
      idle_pct = 64;
      random_phase(PER_PHASE);

      wait_drain();
      $display("covered pixel writes in and out of the image, %0d point beats over",
               point_count);
      $display("several csr settings, %0d colored points checked, idle mixes 0/38/64",
               color_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
